>>> design/nsd_pkg.sv
package nsd_pkg;

  localparam int NSD_COUNTER_WIDTH = 32;
  localparam int NUM_CNT = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 32;
  // threshold is (8*count - 28) / 256
  localparam int THR_W = CNT_W + 3 - 8;
  localparam int WORD_W = 64;
  localparam int SALTS = 8;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_CLEAR = 2'd2
  } nsd_kind_t;

  typedef struct packed {
    logic             latch_byte;
    logic             rd_incr;
    logic [2:0]       salt;
    logic             commit;
    logic             latch_thr;
    logic             rd_scan;
    logic [IDX_W-1:0] scan_addr;
    logic             clear;
  } nsd_cmd_t;

  typedef struct packed {
    logic [3:0] num_salts;
  } nsd_status_t;

  localparam logic [7:0] PERM [256] = '{
    8'h02, 8'hD6, 8'h9E, 8'h6F, 8'hF9, 8'h1D, 8'h04, 8'hAB, 8'hD0, 8'h22, 8'h16, 8'h1F,
    8'hD8, 8'h73, 8'hA1, 8'hAC, 8'h3B, 8'h70, 8'h62, 8'h96, 8'h1E, 8'h6E, 8'h8F, 8'h39,
    8'h9D, 8'h05, 8'h14, 8'h4A, 8'hA6, 8'hBE, 8'hAE, 8'h0E, 8'hCF, 8'hB9, 8'h9C, 8'h9A,
    8'hC7, 8'h68, 8'h13, 8'hE1, 8'h2D, 8'hA4, 8'hEB, 8'h51, 8'h8D, 8'h64, 8'h6B, 8'h50,
    8'h23, 8'h80, 8'h03, 8'h41, 8'hEC, 8'hBB, 8'h71, 8'hCC, 8'h7A, 8'h86, 8'h7F, 8'h98,
    8'hF2, 8'h36, 8'h5E, 8'hEE, 8'h8E, 8'hCE, 8'h4F, 8'hB8, 8'h32, 8'hB6, 8'h5F, 8'h59,
    8'hDC, 8'h1B, 8'h31, 8'h4C, 8'h7B, 8'hF0, 8'h63, 8'h01, 8'h6C, 8'hBA, 8'h07, 8'hE8,
    8'h12, 8'h77, 8'h49, 8'h3C, 8'hDA, 8'h46, 8'hFE, 8'h2F, 8'h79, 8'h1C, 8'h9B, 8'h30,
    8'hE3, 8'h00, 8'h06, 8'h7E, 8'h2E, 8'h0F, 8'h38, 8'h33, 8'h21, 8'hAD, 8'hA5, 8'h54,
    8'hCA, 8'hA7, 8'h29, 8'hFC, 8'h5A, 8'h47, 8'h69, 8'h7D, 8'hC5, 8'h95, 8'hB5, 8'hF4,
    8'h0B, 8'h90, 8'hA3, 8'h81, 8'h6D, 8'h25, 8'h55, 8'h35, 8'hF5, 8'h75, 8'h74, 8'h0A,
    8'h26, 8'hBF, 8'h19, 8'h5C, 8'h1A, 8'hC6, 8'hFF, 8'h99, 8'h5D, 8'h84, 8'hAA, 8'h66,
    8'h3E, 8'hAF, 8'h78, 8'hB3, 8'h20, 8'h43, 8'hC1, 8'hED, 8'h24, 8'hEA, 8'hE6, 8'h3F,
    8'h18, 8'hF3, 8'hA0, 8'h42, 8'h57, 8'h08, 8'h53, 8'h60, 8'hC3, 8'hC0, 8'h83, 8'h40,
    8'h82, 8'hD7, 8'h09, 8'hBD, 8'h44, 8'h2A, 8'h67, 8'hA8, 8'h93, 8'hE0, 8'hC2, 8'h56,
    8'h9F, 8'hD9, 8'hDD, 8'h85, 8'h15, 8'hB4, 8'h8A, 8'h27, 8'h28, 8'h92, 8'h76, 8'hDE,
    8'hEF, 8'hF8, 8'hB2, 8'hB7, 8'hC9, 8'h3D, 8'h45, 8'h94, 8'h4B, 8'h11, 8'h0D, 8'h65,
    8'hD5, 8'h34, 8'h8B, 8'h91, 8'h0C, 8'hFA, 8'h87, 8'hE9, 8'h7C, 8'h5B, 8'hB1, 8'h4D,
    8'hE5, 8'hD4, 8'hCB, 8'h10, 8'hA2, 8'h17, 8'h89, 8'hBC, 8'hDB, 8'hB0, 8'hE2, 8'h97,
    8'h88, 8'h52, 8'hF7, 8'h48, 8'hD3, 8'h61, 8'h2C, 8'h3A, 8'h2B, 8'hD1, 8'h8C, 8'hFB,
    8'hF1, 8'hCD, 8'hE4, 8'h6A, 8'hE7, 8'hA9, 8'hFD, 8'hC4, 8'h37, 8'hC8, 8'hD2, 8'hF6,
    8'hDF, 8'h58, 8'h72, 8'h4E
  };

  // trigram index of bytes x, y, z under salt s
  function automatic logic [7:0] nsd_mix(input logic [7:0] x, input logic [7:0] y,
                                         input logic [7:0] z, input logic [2:0] s);
    logic [7:0]  p;
    logic [11:0] qw;
    logic [7:0]  r;
    p  = PERM[x + {5'd0, s}];
    qw = PERM[y] * {s, 1'b1};
    r  = PERM[z ^ PERM[{5'd0, s}]];
    return (p ^ qw[7:0]) + r;
  endfunction

endpackage

>>> design/nsd_ram.sv
module nsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/nsd_ctrl.sv
module nsd_ctrl import nsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_kind,
  input  nsd_status_t status,
  output logic        busy,
  output nsd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTE,
    ST_FIN
  } state_t;

  state_t           state_r;
  logic [3:0]       salt_r;
  logic [IDX_W-1:0] scan_r;
  logic             accept;
  logic             more_salts;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign more_salts = (salt_r < status.num_salts);

  always_comb begin
    cmd            = '0;
    cmd.latch_byte = accept && (in_kind == KIND_DATA);
    cmd.latch_thr  = accept && (in_kind == KIND_FINAL);
    cmd.clear      = accept && (in_kind == KIND_CLEAR);
    cmd.salt       = salt_r[2:0];
    cmd.scan_addr  = scan_r;
    cmd.rd_incr    = (state_r == ST_BYTE) && more_salts;
    cmd.commit     = (state_r == ST_BYTE) && !more_salts;
    cmd.rd_scan    = (state_r == ST_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      salt_r  <= '0;
      scan_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          salt_r <= '0;
          scan_r <= '0;
          if (accept && (in_kind == KIND_DATA)) begin
            state_r <= ST_BYTE;
          end else if (accept && (in_kind == KIND_FINAL)) begin
            state_r <= ST_FIN;
          end
        end
        ST_BYTE: begin
          if (more_salts) begin
            salt_r <= salt_r + 4'd1;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_FIN: begin
          scan_r <= scan_r + 1'b1;
          if (&scan_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/nsd_datapath.sv
module nsd_datapath import nsd_pkg::*; #(
  parameter int COUNTER_WIDTH = NSD_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  nsd_cmd_t          cmd,
  output nsd_status_t       status,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [1:0]        out_word_index,
  output logic              out_last_word
);

  localparam int CMP_W = (COUNTER_WIDTH > THR_W) ? COUNTER_WIDTH : THR_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [7:0]               hist_r [4];
  logic [7:0]               b0_r;
  logic [CNT_W-1:0]         count_r;
  logic [THR_W-1:0]         thr_r;
  logic [NUM_CNT-1:0]       valid_r;
  logic                     pend_inc_r;
  logic                     pend_scan_r;
  logic [IDX_W-1:0]         pend_addr_r;
  logic                     rd_vld_r;
  logic                     rd_fwd_r;
  logic [COUNTER_WIDTH-1:0] fwd_data_r;
  logic [WORD_W-1:0]        word_r;
  logic                     out_valid_r;
  logic [WORD_W-1:0]        out_word_r;
  logic [1:0]               out_idx_r;
  logic                     out_last_r;

  logic [7:0]               mx, my, mz;
  logic [IDX_W-1:0]         mix_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic [COUNTER_WIDTH-1:0] ram_q;
  logic [COUNTER_WIDTH-1:0] cur;
  logic [COUNTER_WIDTH-1:0] wr_data;
  logic                     above;
  logic [5:0]               bit_pos;
  logic [WORD_W-1:0]        word_nxt;
  logic [CNT_W+2:0]         total;
  logic [THR_W-1:0]         thr_nxt;
  logic                     word_done;

  always_comb begin
    unique case (cmd.salt)
      3'd0:    begin mx = b0_r;      my = hist_r[0]; mz = hist_r[1]; end
      3'd1:    begin mx = b0_r;      my = hist_r[0]; mz = hist_r[2]; end
      3'd2:    begin mx = b0_r;      my = hist_r[1]; mz = hist_r[2]; end
      3'd3:    begin mx = b0_r;      my = hist_r[0]; mz = hist_r[3]; end
      3'd4:    begin mx = b0_r;      my = hist_r[1]; mz = hist_r[3]; end
      3'd5:    begin mx = b0_r;      my = hist_r[2]; mz = hist_r[3]; end
      3'd6:    begin mx = hist_r[3]; my = hist_r[0]; mz = b0_r;      end
      default: begin mx = hist_r[3]; my = hist_r[2]; mz = b0_r;      end
    endcase
  end

  assign mix_idx = nsd_mix(mx, my, mz, cmd.salt);
  assign rd_addr = cmd.rd_scan ? cmd.scan_addr : mix_idx;

  nsd_ram #(
    .WIDTH(COUNTER_WIDTH),
    .DEPTH(NUM_CNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (pend_inc_r),
    .waddr (pend_addr_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // never-written counters read as zero; back-to-back hits take the fresh value
  assign cur       = rd_fwd_r ? fwd_data_r : (rd_vld_r ? ram_q : '0);
  assign wr_data   = (cur == CNT_MAX) ? cur : cur + 1'b1;
  assign above     = CMP_W'(cur) > CMP_W'(thr_r);
  assign bit_pos   = pend_addr_r[5:0];
  assign word_done = pend_scan_r && (&bit_pos);

  always_comb begin
    word_nxt          = word_r;
    word_nxt[bit_pos] = above;
  end

  assign total   = {count_r, 3'b000} - (CNT_W + 3)'(28);
  assign thr_nxt = (count_r > CNT_W'(4)) ? total[CNT_W+2:8] : '0;

  always_comb begin
    if (count_r >= CNT_W'(4)) begin
      status.num_salts = 4'(SALTS);
    end else if (count_r == CNT_W'(3)) begin
      status.num_salts = 4'd3;
    end else if (count_r == CNT_W'(2)) begin
      status.num_salts = 4'd1;
    end else begin
      status.num_salts = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      hist_r      <= '{default: '0};
      pend_inc_r  <= 1'b0;
      pend_scan_r <= 1'b0;
      rd_fwd_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_r <= '0;
        count_r <= '0;
        hist_r  <= '{default: '0};
      end else begin
        if (pend_inc_r) begin
          valid_r[pend_addr_r] <= 1'b1;
        end
        if (cmd.commit) begin
          hist_r[3] <= hist_r[2];
          hist_r[2] <= hist_r[1];
          hist_r[1] <= hist_r[0];
          hist_r[0] <= b0_r;
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
        end
      end
      pend_inc_r  <= cmd.rd_incr;
      pend_scan_r <= cmd.rd_scan;
      rd_vld_r    <= valid_r[rd_addr];
      rd_fwd_r    <= pend_inc_r && (pend_addr_r == rd_addr);
      out_valid_r <= word_done;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= rd_addr;
    fwd_data_r  <= wr_data;
    if (cmd.latch_byte) begin
      b0_r <= in_data_byte;
    end
    if (cmd.latch_thr) begin
      thr_r <= thr_nxt;
    end
    if (pend_scan_r) begin
      word_r <= word_nxt;
    end
    if (word_done) begin
      out_word_r <= word_nxt;
      out_idx_r  <= pend_addr_r[7:6];
      out_last_r <= &pend_addr_r[7:6];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  a_no_mixed_reads: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_incr && cmd.rd_scan))
    else $error("increment and scan reads issued together");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !pend_inc_r)
    else $error("clear collides with a counter write");

  a_word_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(pend_scan_r))
    else $error("digest word strobed without a scan read");

  a_commit_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.rd_incr && !cmd.rd_scan)
    else $error("window shifted while counters still being read");

endmodule

>>> design/nilsimsa_digest.sv
// Nilsimsa digest engine. A transaction is taken at a clock edge where start is high and
// busy is low. A data byte (in_kind 0) is followed by one counter increment per cycle
// through the read and write ports of the 256-entry counter memory: 0, 1, 3 or 8
// increments depending on the byte count, and busy stays high until they and the window
// shift are done. Finalize (in_kind 1) scans all 256 counters one per cycle against the
// count-derived threshold while busy, and the four digest words are strobed on out_valid
// for one cycle each, in order of word index. Digest words cannot be held off, so take
// them when strobed. Clear (in_kind 2) and the unused code do not raise busy. State
// survives finalize.
module nilsimsa_digest import nsd_pkg::*; #(
  parameter int COUNTER_WIDTH = NSD_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [1:0]        out_word_index,
  output logic              out_last_word
);

  nsd_cmd_t    cmd;
  nsd_status_t status;

  nsd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  nsd_datapath #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
